### sv/pdq_pkg.sv
// Shared types and codes for the packet descriptor queue.
package pdq_pkg;

  // Field widths fixed by the descriptor format
  localparam int HANDLE_W = 32;
  localparam int SIZE_W   = 24;
  localparam int DUR_W    = 32;
  localparam int STREAM_W = 8;
  localparam int SERIAL_W = 16;
  localparam int BYTES_W  = 30;
  localparam int DTOT_W   = 38;

  // Request kinds carried on in_tuser
  typedef enum logic [2:0] {
    KIND_PUT    = 3'd0,
    KIND_MARKER = 3'd1,
    KIND_GET    = 3'd2,
    KIND_FLUSH  = 3'd3,
    KIND_START  = 3'd4,
    KIND_ABORT  = 3'd5
  } pdq_kind_t;

  // Result status carried on out_tuser
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_ABORTED = 2'd2,
    ST_FULL    = 2'd3
  } pdq_status_t;

  // One queued descriptor
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic [DUR_W-1:0]    duration;
    logic [STREAM_W-1:0] stream;
    logic [SERIAL_W-1:0] serial;
    logic                marker;
  } pdq_entry_t;

  // Per-cell control from the queue controller
  typedef struct packed {
    logic load;   // capture the new entry
    logic shift;  // take the neighbor's entry (dequeue)
  } pdq_cell_ctl_t;

endpackage

### sv/packet_descriptor_queue_with_serial_core.sv
// Top level: descriptor queue built as a chain of shifting cells plus controller.
// Each accepted request raises out_tvalid with its result in the cycle after it is accepted.
// Throughput: one request per cycle while results are taken; the single output
// register stalls the input when a result waits and out_tready is low.
// Cell 0 always holds the head entry, so a get reads it directly and shifts the chain.
// Reset (rst_n low, synchronous) clears count, totals and abort flag and sets the
// serial to all ones; cell contents are not cleared and need no clearing pass.
module packet_descriptor_queue_with_serial_core
  import pdq_pkg::*;
#(
  parameter int QUEUE_DEPTH    = 64,
  parameter int ENTRY_OVERHEAD = 96
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // [31:0] pkt_handle, [55:32] pkt_size, [87:56] pkt_duration, [95:88] pkt_stream
  input  logic [95:0]         in_tdata,
  // [2:0] kind
  input  logic [2:0]          in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // [31:0] out_handle, [55:32] out_size, [87:56] out_duration, [95:88] out_stream,
  // [111:96] out_serial, entry_count (CW bits), byte_total (30), duration_total (38),
  // zero fill to whole bytes
  output logic [((180 + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0] out_tdata,
  // [1:0] status, [2] out_is_marker
  output logic [2:0]          out_tuser
);

  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_W = ((180 + CW + 7) / 8) * 8;
  localparam logic [CW-1:0]      DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [BYTES_W-1:0] OVH_C   = BYTES_W'(ENTRY_OVERHEAD);

  // Queue state
  logic [CW-1:0]       count_r, count_nxt;
  logic [BYTES_W-1:0]  bytes_r, bytes_nxt;
  logic [DTOT_W-1:0]   dtot_r, dtot_nxt;
  logic [SERIAL_W-1:0] serial_r, serial_nxt;
  logic                aborted_r, aborted_nxt;

  // Result register
  logic                out_valid_r;
  pdq_status_t         status_r, status_nxt;
  pdq_entry_t          res_r, res_nxt;
  logic [CW-1:0]       res_count_r;
  logic [BYTES_W-1:0]  res_bytes_r;
  logic [DTOT_W-1:0]   res_dtot_r;

  pdq_kind_t           kind;
  pdq_entry_t          new_entry;
  pdq_entry_t          cell_q [QUEUE_DEPTH];
  logic                fire;
  logic                enq_ok;
  logic                do_get;
  logic                is_marker;

  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;
  assign kind      = pdq_kind_t'(in_tuser);
  assign is_marker = (kind != KIND_PUT);

  // Decode the request and work out the next state and result
  always_comb begin
    count_nxt   = count_r;
    bytes_nxt   = bytes_r;
    dtot_nxt    = dtot_r;
    serial_nxt  = serial_r;
    aborted_nxt = aborted_r;
    status_nxt  = ST_OK;
    res_nxt     = '0;
    enq_ok      = 1'b0;
    do_get      = 1'b0;
    case (kind)
      KIND_PUT, KIND_MARKER, KIND_START: begin
        if (kind == KIND_START) begin
          aborted_nxt = 1'b0;
        end
        if (aborted_r && kind != KIND_START) begin
          status_nxt = ST_ABORTED;
        end else if (count_r == DEPTH_C) begin
          status_nxt = ST_FULL;
        end else begin
          enq_ok = 1'b1;
          if (is_marker) begin
            serial_nxt = serial_r + 16'd1;
          end
        end
      end
      KIND_GET: begin
        if (aborted_r) begin
          status_nxt = ST_ABORTED;
        end else if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          do_get = 1'b1;
        end
      end
      KIND_FLUSH: begin
        count_nxt = '0;
        bytes_nxt = '0;
        dtot_nxt  = '0;
      end
      KIND_ABORT: begin
        aborted_nxt = 1'b1;
      end
      default: begin
      end
    endcase
    // Update counters and totals for an enqueue or dequeue
    if (enq_ok) begin
      count_nxt = count_r + CW'(1);
      bytes_nxt = bytes_r + BYTES_W'(new_entry.size) + OVH_C;
      dtot_nxt  = dtot_r + DTOT_W'(new_entry.duration);
    end
    if (do_get) begin
      res_nxt   = cell_q[0];
      count_nxt = count_r - CW'(1);
      bytes_nxt = bytes_r - BYTES_W'(cell_q[0].size) - OVH_C;
      dtot_nxt  = dtot_r - DTOT_W'(cell_q[0].duration);
    end
  end

  // Build the entry to queue; markers carry no descriptor and take the raised serial
  always_comb begin
    new_entry        = '0;
    new_entry.serial = is_marker ? serial_r + SERIAL_W'(1) : serial_r;
    new_entry.marker = is_marker;
    if (!is_marker) begin
      new_entry.handle   = in_tdata[31:0];
      new_entry.size     = in_tdata[55:32];
      new_entry.duration = in_tdata[87:56];
      new_entry.stream   = in_tdata[95:88];
    end
  end

  // Chain of cells: cell 0 is the head, a new entry loads into the cell at index count
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    pdq_cell_ctl_t ctl;
    pdq_entry_t    nbr;
    assign ctl.load  = fire && enq_ok && (count_r == CW'(i));
    assign ctl.shift = fire && do_get;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    pdq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_entry (new_entry),
      .nbr_entry (nbr),
      .entry     (cell_q[i])
    );
  end

  // Hold queue state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      bytes_r     <= '0;
      dtot_r      <= '0;
      serial_r    <= '1;
      aborted_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r   <= count_nxt;
        bytes_r   <= bytes_nxt;
        dtot_r    <= dtot_nxt;
        serial_r  <= serial_nxt;
        aborted_r <= aborted_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      status_r    <= status_nxt;
      res_r       <= res_nxt;
      res_count_r <= count_nxt;
      res_bytes_r <= bytes_nxt;
      res_dtot_r  <= dtot_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {res_r.marker, status_r};
  assign out_tdata  = OUT_W'({res_dtot_r, res_bytes_r, res_count_r, res_r.serial,
                              res_r.stream, res_r.duration, res_r.size, res_r.handle});

endmodule

### sv/pdq_cell.sv
// One storage cell of the shifting descriptor chain.
module pdq_cell
  import pdq_pkg::*;
(
  input  logic          clk,
  input  pdq_cell_ctl_t ctl,
  input  pdq_entry_t    new_entry,
  input  pdq_entry_t    nbr_entry,
  output pdq_entry_t    entry
);

  pdq_entry_t entry_r;

  // Load a new entry at the tail, or advance toward the head on a dequeue
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry_r <= new_entry;
    end else if (ctl.shift) begin
      entry_r <= nbr_entry;
    end
  end

  assign entry = entry_r;

endmodule

### sv/pdq_checker.sv
// Port-level assertions for the descriptor queue, bound to the top level.
module pdq_checker
  import pdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [((180 + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0] out_tdata,
  input logic [2:0]          out_tuser
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0] res_count;
  assign res_count = out_tdata[112 + CW - 1:112];

  // Every accepted request yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("accepted request produced no result");

  // Stalled result keeps its payload
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(out_tdata) && $stable(out_tuser)))
    else $error("result changed while stalled");

  // Empty answer only when nothing is held
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1:0] == ST_EMPTY) |-> (res_count == '0))
    else $error("empty status with entries held");

  // Full answer only when the queue is at depth
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1:0] == ST_FULL) |-> (res_count == CW'(QUEUE_DEPTH)))
    else $error("full status below depth");

  // A dequeued marker comes only with a successful get
  a_marker_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2]) |-> (out_tuser[1:0] == ST_OK))
    else $error("marker flag on failed request");

endmodule

bind packet_descriptor_queue_with_serial_core pdq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_pdq_checker (.*);
